// ===== sv/tspmt_pkg.sv =====
// ----------------------------------------------------------------------------
// tspmt_pkg: shared types for the PMT stream-entry parser
// Parse phases, widths and the record passed from the parser front to the
// result queue.
// ----------------------------------------------------------------------------
package tspmt_pkg;

	localparam int LEN_W  = 11;  // payload length / byte offset
	localparam int SKIP_W = 12;  // descriptor loop lengths
	localparam int PID_W  = 13;
	localparam int KIND_W = 8;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HDR    = 3'd1,
		PH_SKIP   = 3'd2,
		PH_ENTRY  = 3'd3,
		PH_PID_HI = 3'd4,
		PH_PID_LO = 3'd5,
		PH_ESL_HI = 3'd6,
		PH_ESL_LO = 3'd7
	} phase_t;

	// One record per byte that causes results: an entry, a close, or both.
	typedef struct packed {
		logic              has_entry;
		logic              has_done;
		logic [PID_W-1:0]  pid;
		logic [KIND_W-1:0] kind;
		logic              trunc;
	} rec_t;

endpackage

// ===== sv/tspmt_front.sv =====
// ----------------------------------------------------------------------------
// tspmt_front: byte-level PMT section parser
// Walks the header, program info skip and stream entries one byte per cycle while
// accept is high, and pushes a result record for each byte that closes an entry or payload.
// ----------------------------------------------------------------------------
module tspmt_front #(
	parameter int MAX_PAYLOAD_BYTES = 1024,
	parameter int CRC_BYTES         = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  data_byte,
	input  logic                        first_byte,
	input  logic [tspmt_pkg::LEN_W-1:0] payload_length,
	output logic                        push,
	output tspmt_pkg::rec_t             rec
);
	import tspmt_pkg::*;

	localparam logic [LEN_W+1:0] MAX_L = (LEN_W+2)'(MAX_PAYLOAD_BYTES);
	localparam logic [LEN_W-1:0] CRC_L = LEN_W'(CRC_BYTES);

	phase_t              phase_q, ph_eff, ph_mid, ph_d;
	logic [LEN_W-1:0]    off_q, off_eff, off_d;
	logic [SKIP_W-1:0]   skip_q, skip_eff, skip_mid, skip_d;
	logic [LEN_W-1:0]    len_q, len_sat, len_eff, limit;
	logic [KIND_W-1:0]   kind_q, kind_d;
	logic [4:0]          high_q, high_d;
	logic                active, last;

	always_comb begin
		len_sat = payload_length;
		if (len_sat == '0) begin
			len_sat = LEN_W'(1);
		end
		if ({2'b00, len_sat} > MAX_L) begin
			len_sat = MAX_L[LEN_W-1:0];
		end
	end

	// Next state
	always_comb begin
		active   = accept && (first_byte || phase_q != PH_IDLE);
		len_eff  = first_byte ? len_sat : len_q;
		off_eff  = first_byte ? '0 : off_q;
		skip_eff = first_byte ? '0 : skip_q;
		ph_eff   = first_byte ? PH_HDR : phase_q;
		limit    = (len_eff > CRC_L) ? len_eff - CRC_L : '0;

		ph_mid   = ph_eff;
		skip_mid = skip_eff;
		kind_d   = kind_q;
		high_d   = high_q;
		case (ph_eff)
			PH_HDR: begin
				if (off_eff == LEN_W'(2)) begin
					high_d = {1'b0, data_byte[3:0]};
				end else if (off_eff == LEN_W'(3)) begin
					skip_mid = {high_q[3:0], data_byte};
					ph_mid   = ({high_q[3:0], data_byte} != '0) ? PH_SKIP : PH_ENTRY;
				end
			end
			PH_SKIP: begin
				skip_mid = skip_eff - SKIP_W'(1);
				if (skip_mid == '0) begin
					ph_mid = PH_ENTRY;
				end
			end
			PH_ENTRY: begin
				if (off_eff < limit) begin
					kind_d = data_byte;
					ph_mid = PH_PID_HI;
				end
			end
			PH_PID_HI: begin
				high_d = data_byte[4:0];
				ph_mid = PH_PID_LO;
			end
			PH_PID_LO: begin
				ph_mid = PH_ESL_HI;
			end
			PH_ESL_HI: begin
				high_d = {1'b0, data_byte[3:0]};
				ph_mid = PH_ESL_LO;
			end
			PH_ESL_LO: begin
				skip_mid = {high_q[3:0], data_byte};
				ph_mid   = ({high_q[3:0], data_byte} != '0) ? PH_SKIP : PH_ENTRY;
			end
			default: begin
				ph_mid = ph_eff;
			end
		endcase

		last = ({1'b0, off_eff} + (LEN_W+1)'(1)) >= {1'b0, len_eff};
		if (last) begin
			ph_d   = PH_IDLE;
			off_d  = '0;
			skip_d = '0;
		end else begin
			ph_d   = ph_mid;
			off_d  = off_eff + LEN_W'(1);
			skip_d = skip_mid;
		end
	end

	// Outputs
	always_comb begin
		rec.has_entry = active && ph_eff == PH_PID_LO;
		rec.has_done  = active && last;
		rec.pid       = {high_q, data_byte};
		rec.kind      = kind_q;
		rec.trunc     = ph_mid != PH_ENTRY;
		push          = rec.has_entry || rec.has_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			off_q   <= '0;
			skip_q  <= '0;
			len_q   <= '0;
			kind_q  <= '0;
			high_q  <= '0;
		end else if (active) begin
			phase_q <= ph_d;
			off_q   <= off_d;
			skip_q  <= skip_d;
			len_q   <= len_eff;
			kind_q  <= kind_d;
			high_q  <= high_d;
		end
	end

endmodule

// ===== sv/tspmt_queue.sv =====
// ----------------------------------------------------------------------------
// tspmt_queue: result record queue
// Small FIFO between the parser front and the output back end.
// ----------------------------------------------------------------------------
module tspmt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tspmt_pkg::rec_t wr_rec,
	input  logic            pop,
	output tspmt_pkg::rec_t rd_rec,
	output logic            full,
	output logic            empty
);
	import tspmt_pkg::*;

	rec_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full   = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == cnt_q[Q_PTR_W-1:0])
		else $error("queue pointers disagree with count");
`endif

endmodule

// ===== sv/tspmt_back.sv =====
// ----------------------------------------------------------------------------
// tspmt_back: result issue
// Expands each queued record into one or two output results, entry first.
// ----------------------------------------------------------------------------
module tspmt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tspmt_pkg::rec_t head,
	input  logic            empty,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,
	output logic            m_tuser,
	output logic            m_tlast
);
	import tspmt_pkg::*;

	logic sent_entry_q;
	logic show_entry, fire;

	always_comb begin
		show_entry = head.has_entry && !sent_entry_q;
		m_tvalid   = !empty;
		fire       = m_tvalid && m_tready;
		pop        = fire && (!show_entry || !head.has_done);
		m_tuser    = show_entry;
		m_tlast    = !show_entry;
		if (show_entry) begin
			m_tdata = {2'b00, 1'b0, head.kind, head.pid};
		end else begin
			m_tdata = {2'b00, head.trunc, {KIND_W{1'b0}}, {PID_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_entry_q <= 1'b0;
		end else if (fire) begin
			sent_entry_q <= show_entry && head.has_done;
		end
	end

endmodule

// ===== sv/ts_pmt_stream_entry_parser.sv =====
// ----------------------------------------------------------------------------
// ts_pmt_stream_entry_parser: PMT section stream-entry parser
// Parses program map payload bytes into stream entries and a closing result.
//
//  channel | dir | request                | tdata / tuser / tlast
//  --------+-----+------------------------+-----------------------------------
//  s_*     | in  | one payload byte       | data_byte, payload_length / first
//  m_*     | out | one entry or one close | pid, kind, truncated / is_entry /
//          |     |                        | table_done
//
// One byte is taken per cycle while s_tready is high; each record is registered
// in the queue before its results leave. A byte that both finishes an entry and
// closes the payload yields two results in turn; the 4-record queue absorbs this.
// s_tready drops only while the result queue is full (m_tready held low).
// arst_n clears the parse phase, offsets and queue; no warm-up pass.
// ----------------------------------------------------------------------------
module ts_pmt_stream_entry_parser #(
	parameter int MAX_PAYLOAD_BYTES = 1024,
	parameter int CRC_BYTES         = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [7:0] data_byte, [18:8] payload_length, rest 0
	input  logic        s_tuser,  // [0] first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [12:0] es_pid, [20:13] stream_kind,
	                              // [21] truncated, rest 0
	output logic        m_tuser,  // [0] is_entry
	output logic        m_tlast   // table_done
);
	import tspmt_pkg::*;

	logic q_full, q_empty, q_push, q_pop;
	rec_t push_rec, head_rec;
	logic s_fire;

	// Front stalls only on a full queue.
	assign s_tready = !q_full;
	assign s_fire   = s_tvalid && s_tready;

	tspmt_front #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
		.CRC_BYTES        (CRC_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (s_fire),
		.data_byte     (s_tdata[7:0]),
		.first_byte    (s_tuser),
		.payload_length(s_tdata[18:8]),
		.push          (q_push),
		.rec           (push_rec)
	);

	tspmt_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wr_rec(push_rec),
		.pop   (q_pop),
		.rd_rec(head_rec),
		.full  (q_full),
		.empty (q_empty)
	);

	tspmt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head_rec),
		.empty   (q_empty),
		.pop     (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream-entry parser testbench
// Feeds program map payloads byte by byte through the slave stream, predicts
// every entry and table close in a local parser, and checks the master stream
// against it in order. A few directed payloads come first, then random
// sections (well-formed, cut short, abandoned, padded) under four idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

	import tspmt_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int MAX_LEN        = 1024;
	localparam int CRC_LEN        = 4;
	localparam int PHASE_BYTES    = 85;    // random bytes per idle mix
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request moving
	localparam int TAIL_CYCLES    = 20;

	typedef logic [7:0] byte_q_t[$];

	// one request on the slave side
	typedef struct packed {
		logic [7:0]       data;
		logic             first;
		logic [LEN_W-1:0] len;
	} pmt_byte_t;

	// one result on the master side
	typedef struct packed {
		logic              is_entry;
		logic [PID_W-1:0]  pid;
		logic [KIND_W-1:0] kind;
		logic              done;
		logic              trunc;
	} pmt_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	pmt_byte_t   pending_bytes[$];
	pmt_result_t expected_results[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int bytes_queued   = 0;
	int bytes_taken    = 0;
	int entries_seen   = 0;
	int closes_seen    = 0;
	int trunc_seen     = 0;
	int mismatch_count = 0;
	int stall_cycles   = 0;

	logic [PID_W-1:0] last_pid = '0;  // reused now and then for duplicate PIDs

	// local copy of the parser state
	logic [LEN_W-1:0]  pm_offset = '0;
	phase_t            pm_phase  = PH_IDLE;
	logic [SKIP_W-1:0] pm_skip   = '0;
	logic [LEN_W-1:0]  pm_len    = '0;
	logic [KIND_W-1:0] pm_kind   = '0;
	logic [4:0]        pm_hi     = '0;

	ts_pmt_stream_entry_parser #(
		.MAX_PAYLOAD_BYTES(MAX_LEN),
		.CRC_BYTES(CRC_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Parser prediction: one accepted byte in, zero to two results queued
	// ------------------------------------------------------------------
	task automatic parse_byte(input logic [7:0] b, input logic first,
	                          input logic [LEN_W-1:0] len_in);
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] limit;
		pmt_result_t      res;
		len = len_in;
		if (first) begin
			// zero length acts as one, oversized lengths saturate
			if (len == 0)
				len = 1;
			if (len > MAX_LEN)
				len = LEN_W'(MAX_LEN);
			pm_len    = len;
			pm_offset = '0;
			pm_skip   = '0;
			pm_phase  = PH_HDR;
		end else if (pm_phase == PH_IDLE) begin
			return;  // stray byte, no payload open
		end
		limit = (pm_len > CRC_LEN) ? LEN_W'(pm_len - CRC_LEN) : '0;

		case (pm_phase)
			PH_HDR: begin
				// bytes 0..1 are reserved bits and PCR PID, 2..3 program info length
				if (pm_offset == 2) begin
					pm_hi = {1'b0, b[3:0]};
				end else if (pm_offset == 3) begin
					pm_skip = {pm_hi[3:0], b};
					if (pm_skip != 0)
						pm_phase = PH_SKIP;
					else
						pm_phase = PH_ENTRY;
				end
			end
			PH_SKIP: begin
				pm_skip = pm_skip - 1'b1;
				if (pm_skip == 0)
					pm_phase = PH_ENTRY;
			end
			PH_ENTRY: begin
				// an entry only starts below the CRC area
				if (pm_offset < limit) begin
					pm_kind  = b;
					pm_phase = PH_PID_HI;
				end
			end
			PH_PID_HI: begin
				pm_hi    = b[4:0];
				pm_phase = PH_PID_LO;
			end
			PH_PID_LO: begin
				res = '{1'b1, {pm_hi, b}, pm_kind, 1'b0, 1'b0};
				expected_results.push_back(res);
				pm_phase = PH_ESL_HI;
			end
			PH_ESL_HI: begin
				pm_hi    = {1'b0, b[3:0]};
				pm_phase = PH_ESL_LO;
			end
			default: begin
				pm_skip = {pm_hi[3:0], b};
				if (pm_skip != 0)
					pm_phase = PH_SKIP;
				else
					pm_phase = PH_ENTRY;
			end
		endcase

		// close on the last byte; anything but an entry boundary is truncated
		if (pm_offset + 1 >= pm_len) begin
			res = '{1'b0, '0, '0, 1'b1, pm_phase != PH_ENTRY};
			expected_results.push_back(res);
			pm_phase  = PH_IDLE;
			pm_offset = '0;
			pm_skip   = '0;
		end else begin
			pm_offset = pm_offset + 1'b1;
		end
	endtask

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns  mismatch: %s", $realtime, msg);
	endtask

	function automatic string show_result(input pmt_result_t r);
		return $sformatf("entry=%0b pid=0x%04h kind=0x%02h done=%0b trunc=%0b",
		                 r.is_entry, r.pid, r.kind, r.done, r.trunc);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------

	// Well-formed section: header, program descriptors, entries, CRC.
	function automatic byte_q_t build_section(input int n_entries, input int max_desc);
		byte_q_t          sec;
		int               pil;
		int               esl;
		logic [PID_W-1:0] pid;
		pil = $urandom_range(max_desc);
		sec.push_back(8'($urandom));
		sec.push_back(8'($urandom));
		sec.push_back({4'($urandom), 4'(pil >> 8)});
		sec.push_back(8'(pil));
		repeat (pil) sec.push_back(8'($urandom));
		repeat (n_entries) begin
			if ($urandom_range(3) == 0)
				pid = last_pid;
			else
				pid = PID_W'($urandom);
			last_pid = pid;
			esl = $urandom_range(max_desc);
			sec.push_back(8'($urandom));
			sec.push_back({3'($urandom), pid[12:8]});
			sec.push_back(pid[7:0]);
			sec.push_back({4'($urandom), 4'(esl >> 8)});
			sec.push_back(8'(esl));
			repeat (esl) sec.push_back(8'($urandom));
		end
		repeat (CRC_LEN) sec.push_back(8'($urandom));
		return sec;
	endfunction

	// Queue count bytes of a payload declaring len_field; random past the body.
	task automatic push_payload(input byte_q_t body, input logic [LEN_W-1:0] len_field,
	                            input int count);
		pmt_byte_t item;
		for (int i = 0; i < count; i++) begin
			item.data  = (i < body.size()) ? body[i] : 8'($urandom);
			item.first = (i == 0);
			item.len   = (i == 0) ? len_field : LEN_W'($urandom);
			pending_bytes.push_back(item);
		end
		bytes_queued += count;
	endtask

	// Bytes with first_byte low while nothing is open; the parser drops them.
	task automatic push_stray(input int count);
		pmt_byte_t item;
		repeat (count) begin
			item = '{8'($urandom), 1'b0, LEN_W'($urandom)};
			pending_bytes.push_back(item);
		end
	endtask

	task automatic wait_drained;
		while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Slave-side driver and master-side ready
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive
		pmt_byte_t item;
		if (arst_n) begin
			// next request once the current one is taken (or none is up)
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {5'd0, item.len, item.data};
					s_tuser  <= item.first;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on every accepted byte, then checks every result.
	// Input side is handled first so an expectation made at this edge is
	// already queued.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		pmt_result_t got;
		pmt_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata[7:0], s_tuser, s_tdata[18:8]);
				bytes_taken++;
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[12:0], m_tdata[20:13], m_tlast, m_tdata[21]};
				if (got.is_entry)
					entries_seen++;
				if (got.done)
					closes_seen++;
				if (got.done && got.trunc)
					trunc_seen++;
				if (expected_results.size() == 0) begin
					flag_mismatch({"unexpected result ", show_result(got)});
				end else begin
					want = expected_results.pop_front();
					if (got !== want)
						flag_mismatch({"expected ", show_result(want),
						               " got ", show_result(got)});
				end
			end
		end
	end

	// Watchdog: ends the run when no request moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles, %0d results outstanding",
			         stall_cycles, expected_results.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		byte_q_t body;
		byte_q_t sec;
		int      idle_mix[4];
		int      stall_mix[4];
		int      target;
		int      roll;
		int      cut;
		idle_mix  = '{0, 52, 0, 32};
		stall_mix = '{0, 0, 52, 32};

		// directed part
		push_stray(1);  // byte with no payload open
		body = '{8'h00};
		push_payload(body, 11'd0, 1);  // zero length acts as one, closes in header
		// short length: ends inside the header
		body = '{8'hFF, 8'hFF};
		push_payload(body, 11'd2, 2);
		// entry starting just below the CRC area: all-ones kind and PID, its
		// descriptor skip runs past the end so the close is truncated
		body = '{8'hFF, 8'hFF, 8'hF0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		push_payload(body, 11'd9, 9);
		// zero kind and PID, no descriptors, clean close after the CRC
		body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h00, 8'hF0, 8'h00,
		         8'h12, 8'h34, 8'h56, 8'h78};
		push_payload(body, 11'd13, 13);

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait_drained();

		// random part, one idle mix after the other
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_mix[ph];
			recv_stall_pct = stall_mix[ph];
			target = bytes_queued + PHASE_BYTES;
			while (bytes_queued < target) begin
				sec  = build_section($urandom_range(4), ($urandom_range(7) == 0) ? 12 : 4);
				roll = $urandom_range(99);
				if (roll < 70) begin
					push_payload(sec, LEN_W'(sec.size()), sec.size());
				end else if (roll < 80) begin
					// length no longer than the section: may end mid-structure
					cut = $urandom_range(1, sec.size());
					push_payload(sec, LEN_W'(cut), cut);
				end else if (roll < 88) begin
					// abandoned: the next payload's first byte restarts the parser
					cut = $urandom_range(1, sec.size() - 1);
					push_payload(sec, LEN_W'(cut), cut);
					push_payload(sec, LEN_W'(sec.size()), cut);
				end else begin
					// length past the section: padding parsed as more entries
					cut = sec.size() + $urandom_range(1, 8);
					push_payload(sec, LEN_W'(cut), cut);
				end
				if ((roll < 80 || roll >= 88) && $urandom_range(9) == 0)
					push_stray($urandom_range(1, 3));
			end
			// oversized length field: saturates, the payload is still open at the end
			if (ph == 3) begin
				sec = build_section(2, 4);
				push_payload(sec, 11'h7FF, sec.size());
			end
			// sender holds off until every result of this mix is back
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("Covered %0d payload bytes: %0d stream entries and %0d table closes",
		         bytes_taken, entries_seen, closes_seen);
		$display("(%0d truncated) under four sender/receiver idle mixes; %0d mismatches",
		         trunc_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
